FILE: rtl/core/mlptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlptw_pkg: shared constants and helpers of the page table walker
// Geometry of the frame store, virtual address split and status codes.
// ----------------------------------------------------------------------------
package mlptw_pkg;

    localparam int PAGE_OFFSET_BITS = 12;
    localparam int LEVEL_COUNT      = 2;
    localparam int FRAME_COUNT      = 64;

    localparam int IDX_BITS     = PAGE_OFFSET_BITS - 3;
    localparam int FRAME_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FREE_W       = $clog2(FRAME_COUNT + 1);
    localparam int ENTRY_W      = FRAME_W + 1;
    localparam int ADDR_W       = FRAME_W + IDX_BITS;
    localparam int STORE_DEPTH  = FRAME_COUNT * (2 ** IDX_BITS);
    localparam int LV_W         = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int VA_W         = 30;
    localparam int PA_W         = 18;
    localparam int STATUS_W     = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOFRAME  = 2'd2;

    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_ALLOCATE  = 1'b1;

    typedef logic [VA_W-1:0]     va_t;
    typedef logic [PA_W-1:0]     pa_t;
    typedef logic [STATUS_W-1:0] status_t;

    function automatic logic [IDX_BITS-1:0] level_index(input va_t va, input int lv);
        int          sh;
        logic [63:0] wide;
        sh   = PAGE_OFFSET_BITS + IDX_BITS * (LEVEL_COUNT - lv - 1);
        wide = 64'(va) >> sh;
        if (sh >= 64)
        begin
            return '0;
        end
        return wide[IDX_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mlptw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlptw_ram: generic single-port synchronous RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module mlptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  addr,
    input  wire logic [WIDTH-1:0]          wdata,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/multi_level_page_table_walker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_level_page_table_walker_top: page table walker with its own frames
// Translates or allocates a virtual address through a multi-level table.
// ----------------------------------------------------------------------------
// After reset the block sweeps to zero, one entry a cycle, its frame store
// of FRAME_COUNT * 2^(PAGE_OFFSET_BITS-3) entries (32768 here); in_stall stays
// high until the sweep ends. Each level of a request reads the single-port
// table RAM in S_READ, then checks the entry in S_CHECK and, on an allocation
// that finds none, writes a fresh one. A translation with no root, or an
// allocation with no frame left for one, skips the walk. One request is in
// work at a time; the next is taken while a result waits on out_stall.
module multi_level_page_table_walker_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                req_type,
    input  wire mlptw_pkg::va_t      virtual_address,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output mlptw_pkg::pa_t           physical_address,
    output mlptw_pkg::status_t       status
);
    import mlptw_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clear_cnt_reg, clear_cnt_next;
    logic               root_valid_reg, root_valid_next;
    logic [FRAME_W-1:0] root_frame_reg, root_frame_next;
    logic [FREE_W-1:0]  next_free_reg, next_free_next;
    logic               out_valid_reg, out_valid_next;

    logic               kind_reg, kind_next;
    va_t                va_reg, va_next;
    logic [FRAME_W-1:0] cur_reg, cur_next;
    logic [LV_W-1:0]    lv_reg, lv_next;
    pa_t                res_pa_reg, res_pa_next;
    status_t            res_status_reg, res_status_next;
    pa_t                out_pa_reg, out_pa_next;
    status_t            out_status_reg, out_status_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               take_ok;
    logic [FRAME_W-1:0] fresh_frame;
    logic [ADDR_W-1:0]  slot;
    logic               step_ok;
    logic [FRAME_W-1:0] step_frame;
    logic [FRAME_W+PAGE_OFFSET_BITS-1:0] pa_wide;

    assign take_ok     = next_free_reg < FREE_W'(FRAME_COUNT);
    assign fresh_frame = FRAME_W'(next_free_reg);
    assign slot        = {cur_reg, level_index(va_reg, int'(lv_reg))};

    mlptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        root_valid_next = root_valid_reg;
        root_frame_next = root_frame_reg;
        next_free_next  = next_free_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        va_next         = va_reg;
        cur_next        = cur_reg;
        lv_next         = lv_reg;
        res_pa_next     = res_pa_reg;
        res_status_next = res_status_reg;
        out_pa_next     = out_pa_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_addr        = slot;
        ram_wdata       = {fresh_frame, 1'b1};
        step_ok         = 1'b0;
        step_frame      = ram_rdata[ENTRY_W-1:1];
        pa_wide         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we         = 1'b1;
                ram_addr       = clear_cnt_reg;
                ram_wdata      = '0;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = req_type;
                    va_next         = virtual_address;
                    lv_next         = '0;
                    cur_next        = root_frame_reg;
                    res_pa_next     = '0;
                    state_next      = S_READ;
                    if (!root_valid_reg)
                    begin
                        if (req_type == REQ_TRANSLATE)
                        begin
                            res_status_next = STATUS_UNMAPPED;
                            state_next      = S_DONE;
                        end
                        else if (take_ok)
                        begin
                            root_valid_next = 1'b1;
                            root_frame_next = fresh_frame;
                            cur_next        = fresh_frame;
                            next_free_next  = next_free_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_next = STATUS_NOFRAME;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (ram_rdata[0])
                begin
                    step_ok = 1'b1;
                end
                else if (kind_reg == REQ_TRANSLATE)
                begin
                    res_status_next = STATUS_UNMAPPED;
                    state_next      = S_DONE;
                end
                else if (take_ok)
                begin
                    ram_we         = 1'b1;
                    step_ok        = 1'b1;
                    step_frame     = fresh_frame;
                    next_free_next = next_free_reg + 1'b1;
                end
                else
                begin
                    res_status_next = STATUS_NOFRAME;
                    state_next      = S_DONE;
                end
                if (step_ok)
                begin
                    cur_next = step_frame;
                    if (lv_reg == LV_W'(LEVEL_COUNT - 1))
                    begin
                        pa_wide         = {step_frame, va_reg[PAGE_OFFSET_BITS-1:0]};
                        res_status_next = STATUS_OK;
                        res_pa_next     = (kind_reg == REQ_TRANSLATE) ? PA_W'(pa_wide) : '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        lv_next    = lv_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_pa_next     = res_pa_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clear_cnt_reg  <= '0;
            root_valid_reg <= 1'b0;
            root_frame_reg <= '0;
            next_free_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_cnt_reg  <= clear_cnt_next;
            root_valid_reg <= root_valid_next;
            root_frame_reg <= root_frame_next;
            next_free_reg  <= next_free_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        va_reg         <= va_next;
        cur_reg        <= cur_next;
        lv_reg         <= lv_next;
        res_pa_reg     <= res_pa_next;
        res_status_reg <= res_status_next;
        out_pa_reg     <= out_pa_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign physical_address = out_pa_reg;
    assign status           = out_status_reg;

endmodule
`default_nettype wire
